// ===== src/hlrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlrc_pkg
// Shared types and constants of the hashed LRU resource cache.
// ----------------------------------------------------------------------------
package hlrc_pkg;

  localparam int Sets       = 16;
  localparam int QueueLimit = 8;
  localparam int DataBytes  = 8;
  localparam int Ways       = QueueLimit - 1;
  localparam int SetW       = (Sets > 1) ? $clog2(Sets) : 1;
  localparam int WayW       = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int AgeW       = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int DataW      = 8 * DataBytes;
  localparam int LenW       = 4;
  // one memory row holds all ways of a set
  localparam int EntryW     = 1 + 64 + LenW + DataW + AgeW;
  localparam int RowW       = Ways * EntryW;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISS     = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_ZERO_WR  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] key;
    logic [31:0] class_id;
    logic [3:0]  length;
    logic [63:0] write_data;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_data;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic [63:0]      tag;
    logic [LenW-1:0]  len;
    logic [DataW-1:0] data;
    logic [AgeW-1:0]  age;
  } entry_t;

  // classified word passed from front to back
  typedef struct packed {
    req_e             req;
    logic [SetW-1:0]  set;
    logic [63:0]      tag;
    logic [LenW-1:0]  len;
    logic [DataW-1:0] wdata;
  } cmd_t;

  function automatic logic [DataW-1:0] byte_mask(input logic [LenW-1:0] n);
    logic [DataW-1:0] m;
    m = '0;
    for (int b = 0; b < DataBytes; b++) begin
      if (n > b[LenW-1:0]) m[8*b +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

// ===== src/hlrc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlrc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module hlrc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/hlrc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlrc_front
// Accepts request words, saturates length, hashes the set, and keeps a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module hlrc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hlrc_pkg::req_t       req_i,
  input  logic                 push,
  output logic                 full,
  output hlrc_pkg::cmd_t       cmd_o,
  output logic                 cmd_valid_o,
  input  logic                 cmd_take_i
);

  hlrc_pkg::cmd_t        q_mem_q [2];
  logic                  wp_q, rp_q;
  logic [1:0]            cnt_q;
  hlrc_pkg::cmd_t        cmd;
  logic [3:0]            len_sat;
  logic                  do_push, do_pop;

  assign len_sat = (req_i.length > 4'(hlrc_pkg::DataBytes)) ?
                   4'(hlrc_pkg::DataBytes) : req_i.length;

  always_comb begin
    cmd.req   = hlrc_pkg::req_e'(req_i.req_type);
    cmd.set   = hlrc_pkg::SetW'((req_i.key ^ req_i.class_id) % hlrc_pkg::Sets);
    cmd.tag   = {req_i.key, req_i.class_id};
    cmd.len   = len_sat;
    cmd.wdata = req_i.write_data[hlrc_pkg::DataW-1:0];
  end

  assign full        = cnt_q == 2'd2;
  assign do_push     = push && !full;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign do_pop      = cmd_take_i && cmd_valid_o;
  assign cmd_o       = q_mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) q_mem_q[wp_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |=> cnt_q == 2'd2 || $past(do_pop)) else $error("push while full");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |-> cnt_q != 2'd0) else $error("pop of empty queue");

endmodule

// ===== src/hlrc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlrc_back
// Reads a set row, resolves hit / victim / LRU update, writes the row back
// and posts the response into a one-word output register.
// ----------------------------------------------------------------------------
module hlrc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hlrc_pkg::cmd_t       cmd_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_take_o,
  output hlrc_pkg::rsp_t       rsp_o,
  output logic                 empty,
  input  logic                 pop
);

  typedef enum logic [0:0] {S_IDLE, S_EXEC} state_e;

  state_e                        state_q;
  hlrc_pkg::cmd_t                cur_q;
  logic [hlrc_pkg::Ways-1:0]     vld_q [hlrc_pkg::Sets];
  logic [hlrc_pkg::RowW-1:0]     rd_row, wr_row;
  logic                          we;
  logic                          out_full_q;
  hlrc_pkg::rsp_t                rsp_q, rsp_d;
  hlrc_pkg::entry_t              ent [hlrc_pkg::Ways];
  hlrc_pkg::entry_t              nent [hlrc_pkg::Ways];
  logic [hlrc_pkg::Ways-1:0]     nvld;
  logic                          start;

  hlrc_ram #(.Width(hlrc_pkg::RowW), .Depth(hlrc_pkg::Sets)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cur_q.set),
    .wdata_i (wr_row),
    .raddr_i (cmd_i.set),
    .rdata_o (rd_row)
  );

  // take a new word only when the result slot is free or is being popped
  assign start      = state_q == S_IDLE && cmd_valid_i && (!out_full_q || pop);
  assign cmd_take_o = start;
  assign we         = state_q == S_EXEC;
  assign empty      = !out_full_q;
  assign rsp_o      = rsp_q;

  always_comb begin
    logic                       hit, fnd_free;
    logic [hlrc_pkg::WayW-1:0]  hw, vw;
    logic [hlrc_pkg::AgeW-1:0]  ha, va, best;
    logic [hlrc_pkg::DataW-1:0] m;
    hit = 1'b0; fnd_free = 1'b0; hw = '0; vw = '0; best = '0;
    ha = '0; va = '0;
    for (int w = 0; w < hlrc_pkg::Ways; w++) begin
      ent[w] = rd_row[w*hlrc_pkg::EntryW +: hlrc_pkg::EntryW];
      ent[w].valid = vld_q[cur_q.set][w];
    end
    for (int w = hlrc_pkg::Ways-1; w >= 0; w--) begin
      if (ent[w].valid && ent[w].tag == cur_q.tag) begin
        hit = 1'b1; hw = hlrc_pkg::WayW'(w);
      end
    end
    for (int w = hlrc_pkg::Ways-1; w >= 0; w--) begin
      if (!ent[w].valid) begin
        fnd_free = 1'b1; vw = hlrc_pkg::WayW'(w);
      end
    end
    if (!fnd_free) begin
      for (int w = 0; w < hlrc_pkg::Ways; w++) begin
        if (w == 0 || ent[w].age > best) begin
          best = ent[w].age; vw = hlrc_pkg::WayW'(w);
        end
      end
    end
    ha = ent[hw].age;
    va = ent[vw].age;
    m  = hlrc_pkg::byte_mask(cur_q.len);
    for (int w = 0; w < hlrc_pkg::Ways; w++) nent[w] = ent[w];
    rsp_d.status    = hlrc_pkg::ST_OK;
    rsp_d.read_data = '0;
    case (cur_q.req)
      hlrc_pkg::REQ_WRITE: begin
        if (hit) begin
          if (cur_q.len > ent[hw].len) nent[hw].len = cur_q.len;
          nent[hw].data = (ent[hw].data & ~m) | (cur_q.wdata & m);
        end else if (cur_q.len == '0) begin
          rsp_d.status = hlrc_pkg::ST_ZERO_WR;
        end else begin
          for (int w = 0; w < hlrc_pkg::Ways; w++) begin
            if (ent[w].valid && w != int'(vw)) begin
              // close gap over evicted way, then age everyone by one
              if (fnd_free || ent[w].age <= va) nent[w].age = ent[w].age + 1'b1;
            end
          end
          nent[vw].valid = 1'b1;
          nent[vw].tag   = cur_q.tag;
          nent[vw].len   = cur_q.len;
          nent[vw].data  = cur_q.wdata & m;
          nent[vw].age   = '0;
        end
      end
      hlrc_pkg::REQ_READ: begin
        if (!hit) begin
          rsp_d.status = hlrc_pkg::ST_MISS;
        end else if (cur_q.len > ent[hw].len) begin
          rsp_d.status = hlrc_pkg::ST_TOO_LONG;
        end else if (cur_q.len != '0) begin
          for (int w = 0; w < hlrc_pkg::Ways; w++) begin
            if (ent[w].valid && ent[w].age < ha) nent[w].age = ent[w].age + 1'b1;
          end
          nent[hw].age    = '0;
          rsp_d.read_data = 64'(ent[hw].data & m);
        end
      end
      hlrc_pkg::REQ_FLUSH: begin
        if (hit) begin
          nent[hw].valid = 1'b0;
          for (int w = 0; w < hlrc_pkg::Ways; w++) begin
            if (ent[w].valid && ent[w].age > ha) nent[w].age = ent[w].age - 1'b1;
          end
        end
      end
      default: ;
    endcase
    for (int w = 0; w < hlrc_pkg::Ways; w++) begin
      nvld[w] = nent[w].valid;
      wr_row[w*hlrc_pkg::EntryW +: hlrc_pkg::EntryW] = nent[w];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) cur_q <= cmd_i;
    if (state_q == S_EXEC) rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      out_full_q <= 1'b0;
      for (int s = 0; s < hlrc_pkg::Sets; s++) vld_q[s] <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (pop && out_full_q) out_full_q <= 1'b0;
          if (start) state_q <= S_EXEC;
        end
        S_EXEC: begin
          vld_q[cur_q.set] <= nvld;
          out_full_q       <= 1'b1;
          state_q          <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_exec_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> state_q == S_IDLE && out_full_q)
    else $error("exec did not post a response");
  a_start_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> !out_full_q || pop) else $error("start with busy result slot");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_full_q && !pop |=> out_full_q && $stable(rsp_q))
    else $error("result lost");

endmodule

// ===== src/hashed_lru_resource_cache_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_lru_resource_cache_core
// Hashed set-associative store with LRU replacement, queue-style ports.
// ----------------------------------------------------------------------------
// channel  | handshake       | payload
// request  | push / full     | req_i  (req_t)
// response | pop / empty     | rsp_o  (rsp_t)
//
// The back end reads the set row from block RAM as it takes a word, then
// resolves and writes the row back in S_EXEC, and takes the next word only after.
// A two-word queue decouples request acceptance from the back end.
// Reset clears all valid bits at once; no clearing pass is needed.
// A stalled response holds the back end after its current word.
// ----------------------------------------------------------------------------
module hashed_lru_resource_cache_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hlrc_pkg::req_t req_i,
  input  logic           push,
  output logic           full,
  output hlrc_pkg::rsp_t rsp_o,
  output logic           empty,
  input  logic           pop
);

  hlrc_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_take;

  hlrc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .push        (push),
    .full        (full),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_take_i  (cmd_take)
  );

  hlrc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_take_o  (cmd_take),
    .rsp_o       (rsp_o),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the hashed LRU resource cache: a self-checking scoreboard
// predicts status and read data per request and compares every response.
// ----------------------------------------------------------------------------
module tb;

  localparam int IdleLimit = 20000;
  localparam int NumSets   = 16;
  localparam int NumWays   = 7;

  logic           clk_i;
  logic           rst_ni;
  hlrc_pkg::req_t req_i;
  logic           push;
  logic           full;
  hlrc_pkg::rsp_t rsp_o;
  logic           empty;
  logic           pop;

  hashed_lru_resource_cache_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .push  (push),
    .full  (full),
    .rsp_o (rsp_o),
    .empty (empty),
    .pop   (pop)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // shadow copy of the cache contents
  logic        sh_valid [NumSets][NumWays];
  logic [63:0] sh_tag   [NumSets][NumWays];
  logic [3:0]  sh_len   [NumSets][NumWays];
  logic [63:0] sh_data  [NumSets][NumWays];
  int          sh_age   [NumSets][NumWays];

  hlrc_pkg::req_t req_pending[$];
  hlrc_pkg::rsp_t rsp_expected[$];
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_cycles;
  int   mismatches;
  int   idle_count;
  logic timed_out;
  logic stim_done;

  // tags kept in a small pool so hits and evictions happen often
  logic [31:0] key_pool[16];
  logic [31:0] cls_pool[16];

  function automatic logic [63:0] len_mask(input int n);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic hlrc_pkg::rsp_t cache_predict(input hlrc_pkg::req_t r);
    hlrc_pkg::rsp_t rs;
    logic [63:0]    tag;
    int             set, hit, len, v, oldest, a;
    rs   = '0;
    tag  = {r.key, r.class_id};
    set  = int'((r.key ^ r.class_id) & 32'(NumSets - 1));
    len  = (r.length > 4'd8) ? 8 : int'(r.length);
    hit  = -1;
    for (int w = 0; w < NumWays; w++)
      if (sh_valid[set][w] && sh_tag[set][w] == tag && hit < 0) hit = w;
    case (hlrc_pkg::req_e'(r.req_type))
      hlrc_pkg::REQ_WRITE: begin
        if (hit < 0) begin
          if (len == 0) begin
            rs.status = hlrc_pkg::ST_ZERO_WR;
          end else begin
            v = -1;
            oldest = -1;
            for (int w = 0; w < NumWays; w++) begin
              if (v < 0 && !sh_valid[set][w]) v = w;
            end
            if (v < 0) begin
              for (int w = 0; w < NumWays; w++)
                if (sh_age[set][w] > oldest) begin
                  oldest = sh_age[set][w];
                  v = w;
                end
              a = sh_age[set][v];
              for (int w = 0; w < NumWays; w++)
                if (sh_valid[set][w] && sh_age[set][w] > a) sh_age[set][w]--;
            end
            sh_valid[set][v] = 1'b0;
            for (int w = 0; w < NumWays; w++)
              if (sh_valid[set][w]) sh_age[set][w]++;
            sh_valid[set][v] = 1'b1;
            sh_tag[set][v]   = tag;
            sh_len[set][v]   = 4'(len);
            sh_data[set][v]  = r.write_data & len_mask(len);
            sh_age[set][v]   = 0;
          end
        end else begin
          if (len > sh_len[set][hit]) sh_len[set][hit] = 4'(len);
          sh_data[set][hit] = (sh_data[set][hit] & ~len_mask(len))
                            | (r.write_data & len_mask(len));
        end
      end
      hlrc_pkg::REQ_READ: begin
        if (hit < 0) begin
          rs.status = hlrc_pkg::ST_MISS;
        end else if (len > sh_len[set][hit]) begin
          rs.status = hlrc_pkg::ST_TOO_LONG;
        end else if (len > 0) begin
          a = sh_age[set][hit];
          for (int w = 0; w < NumWays; w++)
            if (sh_valid[set][w] && sh_age[set][w] < a) sh_age[set][w]++;
          sh_age[set][hit] = 0;
          rs.read_data = sh_data[set][hit] & len_mask(len);
        end
      end
      hlrc_pkg::REQ_FLUSH: begin
        if (hit >= 0) begin
          a = sh_age[set][hit];
          sh_valid[set][hit] = 1'b0;
          for (int w = 0; w < NumWays; w++)
            if (sh_valid[set][w] && sh_age[set][w] > a) sh_age[set][w]--;
        end
      end
      default: ;
    endcase
    return rs;
  endfunction

  function automatic hlrc_pkg::req_t make_req(input hlrc_pkg::req_e t,
                                              input logic [31:0] k,
                                              input logic [31:0] c, input int n,
                                              input logic [63:0] d);
    hlrc_pkg::req_t r;
    r.req_type   = t;
    r.key        = k;
    r.class_id   = c;
    r.length     = 4'(n);
    r.write_data = d;
    return r;
  endfunction

  function automatic hlrc_pkg::req_t random_req();
    hlrc_pkg::req_t r;
    int             p;
    p = $urandom_range(0, 99);
    r.write_data = {$urandom, $urandom};
    r.length     = (p < 5) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    if (p < 8) begin
      r.key      = $urandom;
      r.class_id = $urandom;
    end else begin
      r.key      = key_pool[$urandom_range(0, 15)];
      r.class_id = cls_pool[$urandom_range(0, 3)];
    end
    p = $urandom_range(0, 99);
    if (p < 45)      r.req_type = hlrc_pkg::REQ_WRITE;
    else if (p < 85) r.req_type = hlrc_pkg::REQ_READ;
    else if (p < 97) r.req_type = hlrc_pkg::REQ_FLUSH;
    else             r.req_type = hlrc_pkg::REQ_NONE;
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push  <= 1'b0;
      req_i <= '0;
    end else begin
      if (push && !full) begin
        rsp_expected.push_back(cache_predict(req_i));
        void'(req_pending.pop_front());
      end
      if (req_pending.size() != 0 &&
          (($urandom_range(0, 99) >= send_idle_pct) || (push && full))) begin
        push  <= 1'b1;
        req_i <= req_pending[0];
      end else begin
        push  <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop        <= 1'b0;
      idle_count <= 0;
      timed_out  <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (rsp_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: %p", rsp_o);
        end else begin
          if (rsp_o.status !== rsp_expected[0].status ||
              rsp_o.read_data !== rsp_expected[0].read_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp status %0d data %h, got status %0d data %h",
                       rsp_expected[0].status, rsp_expected[0].read_data,
                       rsp_o.status, rsp_o.read_data);
          end
          void'(rsp_expected.pop_front());
        end
      end
      if ((push && !full) || (pop && !empty)) idle_count <= 0;
      else if (idle_count >= IdleLimit) timed_out <= 1'b1;
      else idle_count <= idle_count + 1;
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        hold_cycles--;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic run_phase(input int sidle, input int rstall, input int n);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < n; i++) req_pending.push_back(random_req());
    wait (req_pending.size() == 0 || timed_out);
  endtask

  initial begin
    logic [31:0] k;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    mismatches     = 0;
    stim_done      = 1'b0;
    for (int s = 0; s < NumSets; s++)
      for (int w = 0; w < NumWays; w++) begin
        sh_valid[s][w] = 1'b0;
        sh_tag[s][w]   = '0;
        sh_len[s][w]   = '0;
        sh_data[s][w]  = '0;
        sh_age[s][w]   = 0;
      end
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = $urandom;
      cls_pool[i] = $urandom;
    end
    // ten pool keys map into one set per class so it fills and evicts
    for (int i = 0; i < 10; i++) key_pool[i][3:0] = cls_pool[0][3:0];
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every op, write hit growth, too-long read, eviction
    req_pending.push_back(make_req(hlrc_pkg::REQ_READ, '1, '1, 8, '0));
    req_pending.push_back(make_req(hlrc_pkg::REQ_WRITE, '1, '1, 0, '1));
    req_pending.push_back(make_req(hlrc_pkg::REQ_WRITE, '1, '1, 15, '1));
    req_pending.push_back(make_req(hlrc_pkg::REQ_READ, '1, '1, 15, '0));
    req_pending.push_back(make_req(hlrc_pkg::REQ_WRITE, '0, '0, 2, 64'h0123456789abcdef));
    req_pending.push_back(make_req(hlrc_pkg::REQ_READ, '0, '0, 3, '0));
    req_pending.push_back(make_req(hlrc_pkg::REQ_WRITE, '0, '0, 0, '1));
    req_pending.push_back(make_req(hlrc_pkg::REQ_WRITE, '0, '0, 5, 64'hfedcba9876543210));
    req_pending.push_back(make_req(hlrc_pkg::REQ_READ, '0, '0, 0, '0));
    req_pending.push_back(make_req(hlrc_pkg::REQ_READ, '0, '0, 5, '0));
    req_pending.push_back(make_req(hlrc_pkg::REQ_NONE, '0, '0, 8, '1));
    req_pending.push_back(make_req(hlrc_pkg::REQ_FLUSH, '0, '0, 0, '0));
    req_pending.push_back(make_req(hlrc_pkg::REQ_FLUSH, '0, '0, 0, '0));
    req_pending.push_back(make_req(hlrc_pkg::REQ_READ, '0, '0, 1, '0));
    for (int i = 0; i < 9; i++) begin
      k = 32'(i * NumSets + 3);
      req_pending.push_back(make_req(hlrc_pkg::REQ_WRITE, k, '0, 1 + (i % 8),
                                     {$urandom, $urandom}));
    end
    req_pending.push_back(make_req(hlrc_pkg::REQ_READ, 32'(3), '0, 1, '0));
    req_pending.push_back(make_req(hlrc_pkg::REQ_READ, 32'(NumSets * 2 + 3), '0, 3, '0));
    wait (req_pending.size() == 0 || timed_out);

    // long receiver hold while the sender keeps pushing
    hold_cycles = 300;
    run_phase(0, 0, 60);
    run_phase(0, 0, 450);
    run_phase(69, 0, 450);
    run_phase(0, 69, 450);
    run_phase(28, 28, 450);
    stim_done = 1'b1;
    wait (rsp_expected.size() == 0 || timed_out);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && rsp_expected.size() == 0 && !timed_out)
      $display("hashed_lru_resource_cache_core regression: pass");
    else
      $display("hashed_lru_resource_cache_core regression: fail");
    $finish;
  end

  initial begin
    wait (timed_out);
    if (!stim_done || rsp_expected.size() != 0) begin
      $display("hashed_lru_resource_cache_core regression: fail");
      $finish;
    end
  end

endmodule

// ===== hashed_lru_resource_cache_core.f =====
src/hlrc_pkg.sv
src/hlrc_ram.sv
src/hlrc_front.sv
src/hlrc_back.sv
src/hashed_lru_resource_cache_core.sv
tb/tb.sv
